FILE: sv/iplpm_pkg.sv
// shared constants and types for the ipv4 longest-prefix route table
package iplpm_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int PORT_COUNT    = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 6;
  localparam int PORT_W   = 4;
  localparam int TTL_W    = 8;
  localparam int STATUS_W = 3;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 48;

  // command codes carried in tuser on the slave side
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ROUTE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_FORWARDED   = 3'd0,
    ST_NO_ROUTE    = 3'd1,
    ST_TTL_EXPIRED = 3'd2,
    ST_ADDED       = 3'd3,
    ST_REPLACED    = 3'd4,
    ST_FULL        = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic [LEN_W-1:0]  len;
    logic              has_hop;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } entry_t;

endpackage

FILE: sv/ipv4_longest_prefix_router.sv
// ipv4 route table with add-route and longest-prefix forwarding lookup
//
// Each transfer on the slave side is either an add-route command (tuser = 0)
// or a datagram to route (tuser = 1), and gives exactly one result transfer
// on the master side, in order. Routes live in a synchronous table of
// TABLE_ENTRIES entries with one valid flip-flop per entry, so the
// table is empty straight after reset with no clearing pass. Every command
// walks the whole table through the one read port, one entry per cycle, so
// an item occupies the block from acceptance to the next acceptance: the
// scan reads each entry, a last step waits out the final read, and a done
// step forms the result and writes the table back before the return to
// idle. A finished result waits in an output register, so the
// next command is taken while the previous result is still stalled. Status
// codes: 0 forwarded, 1 no route, 2 ttl expired, 3 added, 4 replaced,
// 5 table full; port, next hop and ttl are zero unless forwarded.
module ipv4_longest_prefix_router (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // prefix[31:0], prefix_len[37:32], has_next_hop[38], next_hop_addr[70:39],
  // route_port[74:71], dest_addr[106:75], ttl_in[114:107], zero pad above
  input  logic [iplpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cmd[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_port[3:0], hop_out[35:4], ttl_out[43:36], zero pad above
  output logic [iplpm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status[2:0]
  output logic [iplpm_pkg::STATUS_W-1:0]      m_axis_tuser
);

  localparam logic [iplpm_pkg::IDX_W-1:0] LastIdx =
    iplpm_pkg::IDX_W'(iplpm_pkg::TABLE_ENTRIES - 1);

  function automatic logic [iplpm_pkg::ADDR_W-1:0] len_mask(
    input logic [iplpm_pkg::LEN_W-1:0] len
  );
    logic [iplpm_pkg::ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= 6'd32) begin
      m = '1;
    end else begin
      m = {iplpm_pkg::ADDR_W{1'b1}} << (6'd32 - len);
    end
    return m;
  endfunction

  // input field unpack
  logic [31:0] in_prefix;
  logic [5:0]  in_plen;
  logic        in_has_hop;
  logic [31:0] in_hop;
  logic [3:0]  in_port;
  logic [31:0] in_dest;
  logic [7:0]  in_ttl;
  logic [5:0]  in_plen_sat;

  assign in_prefix   = s_axis_tdata[31:0];
  assign in_plen     = s_axis_tdata[37:32];
  assign in_has_hop  = s_axis_tdata[38];
  assign in_hop      = s_axis_tdata[70:39];
  assign in_port     = s_axis_tdata[74:71];
  assign in_dest     = s_axis_tdata[106:75];
  assign in_ttl      = s_axis_tdata[114:107];
  assign in_plen_sat = (in_plen > 6'd32) ? 6'd32 : in_plen;

  iplpm_pkg::state_e state_q, state_d;

  // held command
  logic                            cmd_q;
  logic [31:0]                     addr_q;   // masked key for add, destination for lookup
  logic [5:0]                      plen_q;
  logic                            has_hop_q;
  logic [31:0]                     hop_q;
  logic [3:0]                      port_q;
  logic [7:0]                      ttl_q;

  // table
  iplpm_pkg::entry_t               mem [iplpm_pkg::TABLE_ENTRIES];
  iplpm_pkg::entry_t               rdata_q;
  logic [iplpm_pkg::TABLE_ENTRIES-1:0] valid_q;
  logic [iplpm_pkg::IDX_W-1:0]     rd_idx_q;
  logic [iplpm_pkg::IDX_W-1:0]     cmp_idx_q;
  logic                            cmp_vld_q;

  // scan results
  logic                            slot_found_q;
  logic [iplpm_pkg::IDX_W-1:0]     slot_idx_q;
  logic                            free_found_q;
  logic [iplpm_pkg::IDX_W-1:0]     free_idx_q;
  logic                            best_found_q;
  logic [5:0]                      best_len_q;
  logic                            best_has_hop_q;
  logic [31:0]                     best_hop_q;
  logic [3:0]                      best_port_q;

  logic                            m_tvalid_q;
  logic [iplpm_pkg::OUT_DATA_W-1:0] m_tdata_q;
  logic [iplpm_pkg::STATUS_W-1:0]  m_tuser_q;

  logic                            accept;
  logic                            out_free;
  logic                            load;
  logic                            ent_valid;
  logic                            key_hit;
  logic                            dst_hit;
  logic                            is_better;
  logic                            wr_en;
  logic [iplpm_pkg::IDX_W-1:0]     wr_idx;
  iplpm_pkg::entry_t               wr_ent;
  iplpm_pkg::status_e              res_status;
  logic [3:0]                      res_port;
  logic [31:0]                     res_hop;
  logic [7:0]                      res_ttl;

  assign s_axis_tready = (state_q == iplpm_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;
  assign load          = (state_q == iplpm_pkg::S_DONE) && out_free;

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  // per-entry compare on the word read last cycle
  assign ent_valid = valid_q[cmp_idx_q];
  assign key_hit   = ent_valid && (rdata_q.key == addr_q);
  assign dst_hit   = ent_valid && ((addr_q & len_mask(rdata_q.len)) == rdata_q.key);
  assign is_better = !best_found_q || (rdata_q.len > best_len_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      iplpm_pkg::S_IDLE: begin
        if (accept) state_d = iplpm_pkg::S_SCAN;
      end
      iplpm_pkg::S_SCAN: begin
        if (rd_idx_q == LastIdx) state_d = iplpm_pkg::S_LAST;
      end
      iplpm_pkg::S_LAST: begin
        state_d = iplpm_pkg::S_DONE;
      end
      iplpm_pkg::S_DONE: begin
        if (out_free) state_d = iplpm_pkg::S_IDLE;
      end
      default: state_d = iplpm_pkg::S_IDLE;
    endcase
  end

  // result and write-back
  always_comb begin
    res_status = iplpm_pkg::ST_NO_ROUTE;
    res_port   = '0;
    res_hop    = '0;
    res_ttl    = '0;
    wr_en      = 1'b0;
    wr_idx     = slot_idx_q;
    wr_ent.key     = addr_q;
    wr_ent.len     = plen_q;
    wr_ent.has_hop = has_hop_q;
    wr_ent.hop     = hop_q;
    wr_ent.port    = port_q;
    if (cmd_q == iplpm_pkg::CMD_ADD) begin
      if (slot_found_q) begin
        res_status = iplpm_pkg::ST_REPLACED;
        wr_en      = load;
      end else if (free_found_q) begin
        res_status = iplpm_pkg::ST_ADDED;
        wr_idx     = free_idx_q;
        wr_en      = load;
      end else begin
        res_status = iplpm_pkg::ST_FULL;
      end
    end else if (!best_found_q || (int'(best_port_q) >= iplpm_pkg::PORT_COUNT)) begin
      res_status = iplpm_pkg::ST_NO_ROUTE;
    end else if (ttl_q <= 8'd1) begin
      res_status = iplpm_pkg::ST_TTL_EXPIRED;
    end else begin
      res_status = iplpm_pkg::ST_FORWARDED;
      res_port   = best_port_q;
      res_hop    = best_has_hop_q ? best_hop_q : addr_q;
      res_ttl    = ttl_q - 8'd1;
    end
  end

  // table storage, one read and one write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_ent;
    end
    rdata_q <= mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= iplpm_pkg::S_IDLE;
      valid_q      <= '0;
      rd_idx_q     <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      slot_found_q <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      m_tvalid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == iplpm_pkg::S_SCAN);
      cmp_idx_q <= rd_idx_q;
      if (state_q == iplpm_pkg::S_SCAN) begin
        rd_idx_q <= (rd_idx_q == LastIdx) ? '0 : rd_idx_q + 1'b1;
      end
      if (accept) begin
        rd_idx_q     <= '0;
        slot_found_q <= 1'b0;
        free_found_q <= 1'b0;
        best_found_q <= 1'b0;
      end else if (cmp_vld_q) begin
        if (cmd_q == iplpm_pkg::CMD_ADD) begin
          if (key_hit && !slot_found_q) slot_found_q <= 1'b1;
          if (!ent_valid && !free_found_q) free_found_q <= 1'b1;
        end else if (dst_hit && is_better) begin
          best_found_q <= 1'b1;
        end
      end
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= s_axis_tuser;
      addr_q    <= (s_axis_tuser == iplpm_pkg::CMD_ROUTE) ? in_dest
                                                          : (in_prefix & len_mask(in_plen_sat));
      plen_q    <= in_plen_sat;
      has_hop_q <= in_has_hop;
      hop_q     <= in_hop;
      port_q    <= in_port;
      ttl_q     <= in_ttl;
    end
    if (cmp_vld_q) begin
      if (cmd_q == iplpm_pkg::CMD_ADD) begin
        if (key_hit && !slot_found_q) slot_idx_q <= cmp_idx_q;
        if (!ent_valid && !free_found_q) free_idx_q <= cmp_idx_q;
      end else if (dst_hit && is_better) begin
        best_len_q     <= rdata_q.len;
        best_has_hop_q <= rdata_q.has_hop;
        best_hop_q     <= rdata_q.hop;
        best_port_q    <= rdata_q.port;
      end
    end
    if (load) begin
      m_tuser_q <= res_status;
      m_tdata_q <= {4'd0, res_ttl, res_hop, res_port};
    end
  end

endmodule
